FILE: hdl/pmix_pkg.sv
`timescale 1ns / 1ps

package pmix_pkg;

   // default sizes of the storage
   localparam int DefBufferDepth = 256;
   localparam int DefVoiceCount  = 8;
   localparam int DefWaveDepth   = 4096;
   localparam int DefMaxChannels = 8;

   // field widths of one beat
   localparam int OpW       = 3;
   localparam int WaveAddrW = 12;
   localparam int SampleW   = 16;
   localparam int IndexW    = 8;
   localparam int LengthW   = 13;
   localparam int ChanW     = 4;
   localparam int VolW      = 16;
   localparam int AmpW      = 15;

   // running channel sum and its magnitude
   localparam int SumW = SampleW + ChanW;
   localparam int MagW = SumW - 1;

   localparam int ReqDataW = 88;
   localparam int RspDataW = 24;

   // operation codes
   localparam logic [OpW-1:0] OP_LOAD  = 3'd0;
   localparam logic [OpW-1:0] OP_TICK  = 3'd1;
   localparam logic [OpW-1:0] OP_NOTE  = 3'd2;
   localparam logic [OpW-1:0] OP_SWAP  = 3'd3;
   localparam logic [OpW-1:0] OP_READ  = 3'd4;

   typedef logic [MagW-1:0] mag_type;
   typedef logic [ChanW-1:0] chan_type;

endpackage

FILE: hdl/pmix_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module pmix_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pmix_pkg::mag_type  dividend,
   input  pmix_pkg::chan_type divisor,
   output logic              done,
   output pmix_pkg::mag_type  quotient
);
   import pmix_pkg::*;

   localparam int CntW = $clog2(MagW + 1);

   logic [ChanW-1:0] rem_ff, rem_in;
   mag_type          quo_ff, quo_in;
   chan_type         dvs_ff, dvs_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [ChanW:0]   trial;
   logic [ChanW:0]   diff;

   // one step of shift and subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[MagW-1]};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CntW'(MagW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[ChanW-1:0];
            quo_in = {quo_ff[MagW-2:0], 1'b1};
         end else begin
            rem_in = trial[ChanW-1:0];
            quo_in = {quo_ff[MagW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   dividend_held: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> cnt_ff == $past(cnt_ff) - 1'b1 || !busy_ff)
      else $error("divider step count skipped");
   no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");
   done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

endmodule

FILE: hdl/polyphonic_sample_mixer.sv
`timescale 1ns / 1ps

// Polyphonic sample mixer. Beats are taken one at a time, and a read waits for the result
// register to empty. A note start or a swap walks the buffer one frame at a time;
// each frame reads every channel through the waveform memory port, divides the sum
// in the shared serial divider and runs the scale and clamp step. A swap does that
// for each buffer position of every sounding voice until its note or the buffer
// ends, and checks each voice slot in turn.
// Reset and swap clear the mix buffer at once through per-entry valid flags.
module polyphonic_sample_mixer #(
   parameter int BUFFER_DEPTH = pmix_pkg::DefBufferDepth,
   parameter int VOICE_COUNT  = pmix_pkg::DefVoiceCount,
   parameter int WAVE_DEPTH   = pmix_pkg::DefWaveDepth,
   parameter int MAX_CHANNELS = pmix_pkg::DefMaxChannels
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // wave_address, wave_word, sample_index, wave_base, wave_length,
   // channel_count, emphasis, zero fill
   input  logic [pmix_pkg::ReqDataW-1:0]   req_tdata,
   // opcode
   input  logic [pmix_pkg::OpW-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // mixed_sample, read_position
   output logic [pmix_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                            csr_wen,
   input  logic [pmix_pkg::AmpW-1:0]       csr_wdata
);
   import pmix_pkg::*;

   localparam int BW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int WW = $clog2(WAVE_DEPTH);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_ACC   = 4'd2;
   localparam logic [3:0] S_DIV   = 4'd3;
   localparam logic [3:0] S_SCALE = 4'd4;
   localparam logic [3:0] S_ADD   = 4'd5;
   localparam logic [3:0] S_SWV   = 4'd6;
   localparam logic [3:0] S_RDB   = 4'd7;
   localparam logic [3:0] S_RSP   = 4'd8;

   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_NOTE = 2'd1;
   localparam logic [1:0] MODE_SWAP = 2'd2;

   // beat fields
   logic [OpW-1:0]       f_op;
   logic [WaveAddrW-1:0] f_addr;
   logic [SampleW-1:0]   f_word;
   logic [IndexW-1:0]    f_idx;
   logic [WaveAddrW-1:0] f_base;
   logic [LengthW-1:0]   f_len;
   logic [ChanW-1:0]     f_ch;
   logic [VolW-1:0]      f_emph;
   logic [ChanW-1:0]     ch_fix;
   logic                 idx_ok;
   logic                 accept;

   assign f_op   = req_tuser;
   assign f_addr = req_tdata[11:0];
   assign f_word = req_tdata[27:12];
   assign f_idx  = req_tdata[35:28];
   assign f_base = req_tdata[47:36];
   assign f_len  = req_tdata[60:48];
   assign f_ch   = req_tdata[64:61];
   assign f_emph = req_tdata[80:65];

   // control state
   logic [3:0]          state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [AmpW-1:0]     amp_ff;
   logic [VW:0]         cur_v_ff, cur_v_in;
   logic [VW-1:0]       slot_ff, slot_in;
   logic [BW:0]         pos_i_ff, pos_i_in;
   logic [ChanW-1:0]    c_ff, c_in;
   logic signed [SumW-1:0] sum_ff, sum_in;
   logic                neg_ff, neg_in;
   logic [MagW-2:0]     mag_ff, mag_in;
   logic [VolW-1:0]     vol_ff, vol_in;
   logic [MagW+VolW-2:0] prod_ff;
   logic                in_range_ff, in_range_in;
   logic [BUFFER_DEPTH-1:0] valid_ff, valid_in;
   logic                rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;

   // voice table
   logic [WaveAddrW-1:0] v_start_ff [VOICE_COUNT];
   logic [LengthW-1:0]   v_len_ff   [VOICE_COUNT];
   logic [ChanW-1:0]     v_chan_ff  [VOICE_COUNT];
   logic [LengthW-1:0]   v_pos_ff   [VOICE_COUNT];
   logic [VolW-1:0]      v_vol_ff   [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] v_act_ff;

   // memories
   logic [SampleW-1:0] wave_mem [WAVE_DEPTH];
   logic [SampleW-1:0] buf_mem  [BUFFER_DEPTH];
   logic [SampleW-1:0] wave_rd_ff;
   logic [SampleW-1:0] buf_rd_ff;

   logic [VW-1:0]        cv;
   logic [ChanW-1:0]     cch;
   logic [BW-1:0]        bi;
   logic [WW-1:0]        wave_ra;
   logic signed [SumW-1:0] sum_nx;
   mag_type              sum_mag;
   logic                 div_start;
   logic                 div_done;
   mag_type              div_quo;
   logic signed [MagW:0] amt;
   logic signed [MagW:0] base_val;
   logic signed [MagW:0] total;
   logic signed [MagW:0] clamped;
   logic signed [MagW:0] amp_pos;
   logic [LengthW:0]     new_pos;
   logic [LengthW+1:0]   pos_end;
   logic                 note_end;
   logic                 write_buf;
   logic                 rsp_load;

   assign cv  = cur_v_ff[VW-1:0];
   assign cch = v_chan_ff[cv];
   assign bi  = pos_i_ff[BW-1:0];

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign idx_ok = (32'(f_idx) < BUFFER_DEPTH);

   // channel count limited to the supported range
   always_comb begin
      priority if (f_ch == '0) begin
         ch_fix = ChanW'(1);
      end else if (32'(f_ch) > MAX_CHANNELS) begin
         ch_fix = ChanW'(MAX_CHANNELS);
      end else begin
         ch_fix = f_ch;
      end
   end

   // channel word address and running sum
   assign wave_ra = WW'(({2'b00, v_start_ff[cv]} + {1'b0, v_pos_ff[cv]}) + (LengthW + 1)'(c_ff));
   assign sum_nx  = sum_ff + SumW'($signed(wave_rd_ff));
   assign sum_mag = sum_nx[SumW-1] ? MagW'(-sum_nx) : MagW'(sum_nx);
   assign div_start = (state_ff == S_ACC) && ((c_ff + 1'b1) >= cch);

   pmix_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (cch),
      .done     (div_done),
      .quotient (div_quo)
   );

   // add with clamp against the buffer entry
   always_comb begin
      amt      = neg_ff ? -$signed({1'b0, prod_ff[MagW+VolW-2:15]})
                        :  $signed({1'b0, prod_ff[MagW+VolW-2:15]});
      base_val = valid_ff[bi] ? (MagW + 1)'($signed(buf_rd_ff)) : '0;
      total    = base_val + amt;
      amp_pos  = $signed({{(MagW + 1 - AmpW){1'b0}}, amp_ff});
      priority if (total > amp_pos) begin
         clamped = amp_pos;
      end else if (total < -amp_pos) begin
         clamped = -amp_pos;
      end else begin
         clamped = total;
      end
   end

   // frame advance
   assign new_pos  = {1'b0, v_pos_ff[cv]} + (LengthW + 1)'(cch);
   assign pos_end  = {1'b0, new_pos} + (LengthW + 2)'(cch);
   assign note_end = pos_end >= (LengthW + 2)'(v_len_ff[cv]);
   assign write_buf = (state_ff == S_ADD);
   assign rsp_load  = (state_ff == S_RSP) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      cur_v_in    = cur_v_ff;
      slot_in     = slot_ff;
      pos_i_in    = pos_i_ff;
      c_in        = c_ff;
      sum_in      = sum_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      vol_in      = vol_ff;
      in_range_in = in_range_ff;
      valid_in    = valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_i_in    = (BW + 1)'(f_idx);
               in_range_in = idx_ok;
               c_in        = '0;
               sum_in      = '0;
               priority if (f_op == OP_TICK) begin
                  mode_in = MODE_TICK;
                  neg_in  = 1'b0;
                  mag_in  = (MagW - 1)'(amp_ff);
                  vol_in  = f_emph;
                  if (idx_ok) state_in = S_SCALE;
               end else if (f_op == OP_NOTE) begin
                  mode_in  = MODE_NOTE;
                  cur_v_in = (VW + 1)'(slot_ff);
                  slot_in  = (32'(slot_ff) == VOICE_COUNT - 1) ? '0 : slot_ff + 1'b1;
                  if (f_len != '0 && idx_ok) state_in = S_RD;
               end else if (f_op == OP_SWAP) begin
                  mode_in  = MODE_SWAP;
                  cur_v_in = '0;
                  valid_in = '0;
                  state_in = S_SWV;
               end else if (f_op == OP_READ) begin
                  state_in = in_range_in ? S_RDB : S_RSP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SWV: begin
            pos_i_in = '0;
            c_in     = '0;
            sum_in   = '0;
            priority if (32'(cur_v_ff) >= VOICE_COUNT) begin
               state_in = S_IDLE;
            end else if (v_act_ff[cv] && v_vol_ff[cv] != '0) begin
               state_in = S_RD;
            end else begin
               cur_v_in = cur_v_ff + 1'b1;
            end
         end
         S_RD: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            sum_in = sum_nx;
            if (div_start) begin
               neg_in   = sum_nx[SumW-1];
               state_in = S_DIV;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_DIV: begin
            vol_in = v_vol_ff[cv];
            if (div_done) begin
               mag_in   = div_quo[MagW-2:0];
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            valid_in[bi] = 1'b1;
            c_in   = '0;
            sum_in = '0;
            if (mode_ff == MODE_TICK) begin
               state_in = S_IDLE;
            end else if (note_end || 32'(pos_i_ff) == BUFFER_DEPTH - 1) begin
               if (mode_ff == MODE_NOTE) begin
                  state_in = S_IDLE;
               end else begin
                  cur_v_in = cur_v_ff + 1'b1;
                  state_in = S_SWV;
               end
            end else begin
               pos_i_in = pos_i_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_RDB: begin
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_TICK;
         cur_v_ff     <= '0;
         slot_ff      <= '0;
         pos_i_ff     <= '0;
         c_ff         <= '0;
         in_range_ff  <= 1'b0;
         valid_ff     <= '0;
         amp_ff       <= {AmpW{1'b1}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         cur_v_ff    <= cur_v_in;
         slot_ff     <= slot_in;
         pos_i_ff    <= pos_i_in;
         c_ff        <= c_in;
         in_range_ff <= in_range_in;
         valid_ff    <= valid_in;
         if (csr_wen) amp_ff <= csr_wdata;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      sum_ff  <= sum_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      vol_ff  <= vol_in;
      prod_ff <= mag_ff * vol_ff;
   end

   // voice table updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICE_COUNT; v++) begin
            v_start_ff[v] <= '0;
            v_len_ff[v]   <= '0;
            v_chan_ff[v]  <= ChanW'(1);
            v_pos_ff[v]   <= '0;
            v_vol_ff[v]   <= '0;
         end
         v_act_ff <= '0;
      end else if (accept && f_op == OP_NOTE) begin
         v_start_ff[slot_ff] <= f_base;
         v_len_ff[slot_ff]   <= f_len;
         v_chan_ff[slot_ff]  <= ch_fix;
         v_pos_ff[slot_ff]   <= '0;
         v_vol_ff[slot_ff]   <= (f_len == '0) ? '0 : f_emph;
         v_act_ff[slot_ff]   <= (f_len != '0);
      end else if (write_buf && mode_ff != MODE_TICK) begin
         if (note_end) begin
            v_act_ff[cv] <= 1'b0;
            v_pos_ff[cv] <= '0;
         end else begin
            v_pos_ff[cv] <= LengthW'(new_pos);
         end
      end
   end

   // waveform memory
   always_ff @(posedge clock) begin
      if (accept && f_op == OP_LOAD) begin
         wave_mem[WW'(f_addr)] <= f_word;
      end
      if (state_ff == S_RD) begin
         wave_rd_ff <= wave_mem[wave_ra];
      end
   end

   // mix buffer
   always_ff @(posedge clock) begin
      if (write_buf) begin
         buf_mem[bi] <= SampleW'(clamped);
      end
      if (state_ff == S_SCALE || state_ff == S_RDB) begin
         buf_rd_ff <= buf_mem[bi];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff[SampleW-1:0] <= (in_range_ff && valid_ff[bi]) ? buf_rd_ff : '0;
         rsp_data_ff[RspDataW-1:SampleW] <= IndexW'(pos_i_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   swap_clears: assert property (@(posedge clock) disable iff (reset)
      accept && f_op == OP_SWAP |=> valid_ff == '0)
      else $error("swap left buffer entries marked valid");
   buffer_index_in_range: assert property (@(posedge clock) disable iff (reset)
      write_buf |-> 32'(pos_i_ff) < BUFFER_DEPTH)
      else $error("buffer write beyond depth");
   channel_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> c_ff < cch)
      else $error("channel fetch beyond frame");
   divider_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside divide step");

endmodule

FILE: tb/pmix_tb_pkg.sv
`timescale 1ns / 1ps

package pmix_tb_pkg;

   // request beat fields, lowest bits last in the declaration
   typedef struct packed {
      logic [6:0]  fill;
      logic [15:0] emphasis;
      logic [3:0]  channel_count;
      logic [12:0] wave_length;
      logic [11:0] wave_base;
      logic [7:0]  sample_index;
      logic [15:0] wave_word;
      logic [11:0] wave_address;
   } req_fields_t;

   // result beat fields
   typedef struct packed {
      logic [7:0]  read_position;
      logic [15:0] mixed_sample;
   } rsp_fields_t;

endpackage

FILE: tb/pmix_checker.sv
`timescale 1ns / 1ps

module pmix_checker
   import pmix_pkg::*;
   import pmix_tb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic [OpW-1:0]      req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_wen,
   input  logic [AmpW-1:0]     csr_wdata,
   output int                  fail_count,
   output int                  pending
);

   localparam int NBuf = DefBufferDepth;
   localparam int NVoice = DefVoiceCount;
   localparam int NWave = DefWaveDepth;

   // predicted block state
   int                  clamp_level;
   logic signed [15:0]  mix_buf [NBuf];
   logic signed [15:0]  wave_mem [NWave];
   int unsigned         v_start [NVoice];
   int unsigned         v_length [NVoice];
   int unsigned         v_chans [NVoice];
   int unsigned         v_pos [NVoice];
   int unsigned         v_vol [NVoice];
   bit                  v_on [NVoice];
   int unsigned         slot_ptr;

   rsp_fields_t         samples_due [$];

   // magnitude scaled by q1.15 volume, truncated toward zero
   function automatic int scale_by_volume(int v, int unsigned vol);
      longint m;
      m = v < 0 ? -v : v;
      m = (m * vol) >>> 15;
      return v < 0 ? -int'(m) : int'(m);
   endfunction

   function automatic void add_with_clamp(int pos, int amount);
      int s;
      s = int'(mix_buf[pos]) + amount;
      if (s > clamp_level) s = clamp_level;
      else if (s < -clamp_level) s = -clamp_level;
      mix_buf[pos] = s[15:0];
   endfunction

   // one frame of a voice into the buffer; returns 1 when the note is done
   function automatic bit mix_one_frame(int v, int pos);
      int sum;
      sum = 0;
      for (int c = 0; c < v_chans[v]; c++)
         sum += int'(wave_mem[(v_start[v] + v_pos[v] + c) % NWave]);
      sum = sum / int'(v_chans[v]);
      add_with_clamp(pos, scale_by_volume(sum, v_vol[v]));
      v_pos[v] += v_chans[v];
      if (v_pos[v] + v_chans[v] >= v_length[v]) begin
         v_on[v] = 0;
         v_pos[v] = 0;
         return 1;
      end
      return 0;
   endfunction

   function automatic void clear_state();
      clamp_level = 32767;
      foreach (mix_buf[i]) mix_buf[i] = '0;
      foreach (wave_mem[i]) wave_mem[i] = '0;
      for (int v = 0; v < NVoice; v++) begin
         v_start[v] = 0;
         v_length[v] = 0;
         v_chans[v] = 1;
         v_pos[v] = 0;
         v_vol[v] = 0;
         v_on[v] = 0;
      end
      slot_ptr = 0;
      samples_due.delete();
   endfunction

   // apply one accepted request beat to the predicted state
   function automatic void apply_request(logic [OpW-1:0] op, req_fields_t f);
      int unsigned ch;
      int unsigned v;
      rsp_fields_t r;
      ch = f.channel_count;
      if (ch == 0) ch = 1;
      if (ch > DefMaxChannels) ch = DefMaxChannels;
      case (op)
         OP_LOAD: wave_mem[f.wave_address % NWave] = f.wave_word;
         OP_TICK: begin
            if (f.sample_index < NBuf)
               add_with_clamp(f.sample_index, scale_by_volume(clamp_level, f.emphasis));
         end
         OP_NOTE: begin
            v = slot_ptr % NVoice;
            slot_ptr = (v + 1) % NVoice;
            v_start[v] = f.wave_base;
            v_length[v] = f.wave_length;
            v_chans[v] = ch;
            v_pos[v] = 0;
            if (f.wave_length == 0) begin
               v_vol[v] = 0;
               v_on[v] = 0;
            end else begin
               v_vol[v] = f.emphasis;
               v_on[v] = 1;
               for (int i = f.sample_index; i < NBuf; i++)
                  if (mix_one_frame(v, i)) break;
            end
         end
         OP_SWAP: begin
            foreach (mix_buf[i]) mix_buf[i] = '0;
            for (int vv = 0; vv < NVoice; vv++) begin
               if (!v_on[vv] || v_vol[vv] == 0) continue;
               for (int i = 0; i < NBuf; i++)
                  if (mix_one_frame(vv, i)) break;
            end
         end
         OP_READ: begin
            r.read_position = f.sample_index;
            r.mixed_sample = f.sample_index < NBuf ? mix_buf[f.sample_index] : '0;
            samples_due.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin
      rsp_fields_t got;
      rsp_fields_t want;
      if (reset) begin
         clear_state();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (samples_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: sample %0d position %0d",
                           $signed(got.mixed_sample), got.read_position);
            end else begin
               want = samples_due.pop_front();
               if (got.mixed_sample !== want.mixed_sample ||
                   got.read_position !== want.read_position) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch at %0t: expected sample %0d pos %0d, got %0d pos %0d",
                              $time, $signed(want.mixed_sample), want.read_position,
                              $signed(got.mixed_sample), got.read_position);
               end
            end
         end
         if (csr_wen) clamp_level = int'(csr_wdata);
         if (req_tvalid && req_tready) apply_request(req_tuser, req_fields_t'(req_tdata));
      end
      pending = samples_due.size();
   end

endmodule

FILE: tb/tb_polyphonic_sample_mixer.sv
`timescale 1ns / 1ps

module tb_polyphonic_sample_mixer;
   import pmix_pkg::*;
   import pmix_tb_pkg::*;

   localparam longint CycleLimit = 60000000;
   localparam int BeatsPerPhase = 140;
   // waveform window that notes read from, wrapping past the top address
   localparam int FillBase = 3840;
   localparam int FillWords = 512;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic [OpW-1:0]      req_tuser = OP_READ;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_wen = 1'b0;
   logic [AmpW-1:0]     csr_wdata = '0;
   int                  fail_count;
   int                  pending;

   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  beats_by_op [8];
   longint              cycle_count = 0;

   polyphonic_sample_mixer DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   pmix_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock)
      rsp_tready = ($urandom_range(99) >= stall_pct);

   // drive one request beat and wait for it to be taken
   task automatic send_beat(logic [OpW-1:0] op, req_fields_t f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      f.fill = '0;
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = f;
      do @(posedge clock); while (!req_tready);
      beats_by_op[op]++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   function automatic req_fields_t random_fields();
      req_fields_t f;
      f = 88'({$urandom, $urandom, $urandom});
      return f;
   endfunction

   // note base inside the filled window, far enough from its end for the note
   function automatic logic [11:0] note_base(int len);
      int span;
      span = (len > DefMaxChannels) ? len : DefMaxChannels;
      return 12'(FillBase + int'($urandom_range(FillWords - span, 0)));
   endfunction

   function automatic req_fields_t note_fields(int idx, int len, int ch, int emph);
      req_fields_t f;
      f = random_fields();
      f.sample_index = 8'(idx);
      f.wave_length = 13'(len);
      f.channel_count = 4'(ch);
      f.emphasis = 16'(emph);
      f.wave_base = note_base(len);
      return f;
   endfunction

   // a read goes behind all earlier work, so its result marks the block idle
   task automatic drain();
      send_beat(OP_READ, random_fields());
      wait (pending == 0);
      repeat (50) @(negedge clock);
   endtask

   task automatic write_clamp(int value);
      csr_wen = 1'b1;
      csr_wdata = 15'(value);
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   // random beat, shaped so that notes mostly end within the buffer
   task automatic send_random_beat();
      req_fields_t f;
      int pick;
      int len;
      f = random_fields();
      pick = $urandom_range(99);
      if (pick < 15) send_beat(OP_LOAD, f);
      else if (pick < 35) begin
         if ($urandom_range(9) == 0) f.emphasis = 16'h8000;
         send_beat(OP_TICK, f);
      end else if (pick < 60) begin
         pick = $urandom_range(99);
         if (pick < 2) len = 0;
         else if (pick < 87) len = $urandom_range(1, 64);
         else if (pick < 97) len = $urandom_range(65, 300);
         else len = $urandom_range(301, FillWords - DefMaxChannels);
         f.wave_length = 13'(len);
         f.wave_base = note_base(len);
         if ($urandom_range(9) == 0) f.emphasis = 16'h8000;
         send_beat(OP_NOTE, f);
      end else if (pick < 63) send_beat(OP_SWAP, f);
      else if (pick < 98) send_beat(OP_READ, f);
      else send_beat(3'($urandom_range(5, 7)), f);
   endtask

   initial begin
      req_fields_t f;
      int clamp_values [5];
      int idle_modes [4][2];
      clamp_values = '{32767, 0, 1, 16384, 0};
      idle_modes = '{'{0, 0}, '{45, 0}, '{0, 45}, '{35, 35}};
      clamp_values[4] = $urandom_range(2, 32766);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the waveform window so that no note reads an unwritten word
      for (int a = 0; a < FillWords; a++) begin
         f = random_fields();
         f.wave_address = 12'(FillBase + a);
         send_beat(OP_LOAD, f);
      end

      // directed: extremes and special cases
      f = random_fields(); f.wave_address = 0; f.wave_word = 16'h8000;
      send_beat(OP_LOAD, f);
      f = random_fields(); f.wave_address = 12'hfff; f.wave_word = 16'h7fff;
      send_beat(OP_LOAD, f);
      send_beat(OP_TICK, note_fields(0, 0, 1, 16'h8000));
      send_beat(OP_TICK, note_fields(255, 0, 1, 16'hffff));
      send_beat(OP_TICK, note_fields(0, 0, 1, 16'h8000));
      send_beat(OP_READ, note_fields(0, 0, 1, 0));
      send_beat(OP_READ, note_fields(255, 0, 1, 0));
      send_beat(OP_NOTE, note_fields(10, 0, 1, 16'h8000));
      send_beat(OP_NOTE, note_fields(250, FillWords - DefMaxChannels, 8, 16'h8000));
      send_beat(OP_NOTE, note_fields(200, 20, 0, 16'hffff));
      send_beat(OP_NOTE, note_fields(240, 40, 15, 16'h4000));
      send_beat(OP_NOTE, note_fields(254, 300, 1, 0));
      send_beat(OP_NOTE, note_fields(0, 1, 1, 16'h8000));
      send_beat(OP_READ, note_fields(250, 0, 1, 0));
      send_beat(OP_READ, note_fields(0, 0, 1, 0));
      send_beat(OP_SWAP, random_fields());
      send_beat(OP_READ, note_fields(0, 0, 1, 0));
      send_beat(OP_READ, note_fields(5, 0, 1, 0));
      send_beat(3'd5, random_fields());
      send_beat(3'd7, random_fields());
      drain();

      // random phases over several clamp levels and idling modes
      for (int p = 0; p < 5; p++) begin
         write_clamp(clamp_values[p]);
         send_idle_pct = idle_modes[p % 4][0];
         stall_pct = idle_modes[p % 4][1];
         for (int n = 0; n < BeatsPerPhase; n++) begin
            send_random_beat();
            if (n == BeatsPerPhase / 2) begin
               wait (pending == 0);
               @(negedge clock);
            end
         end
         drain();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      wait (pending == 0);
      repeat (200) @(negedge clock);

      $display("beats: %0d loads, %0d ticks, %0d notes, %0d swaps, %0d reads, %0d unused",
               beats_by_op[OP_LOAD], beats_by_op[OP_TICK], beats_by_op[OP_NOTE],
               beats_by_op[OP_SWAP], beats_by_op[OP_READ],
               beats_by_op[5] + beats_by_op[6] + beats_by_op[7]);
      $display("five clamp levels including 0 and full scale, four idling modes, %0d errors",
               fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/pmix_pkg.sv
hdl/pmix_div.sv
hdl/polyphonic_sample_mixer.sv
tb/pmix_tb_pkg.sv
tb/pmix_checker.sv
tb/tb_polyphonic_sample_mixer.sv
